// File: rtl/core/vertex_transform_4x4_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Clocked on i_clk, quiet while i_rst_n is low where reset is named.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked outside reset.
`define VT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Property checked at every edge, reset included.
`define VT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define VT_ASSERT(lbl, prop, msg)
`define VT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/vt4x4_pkg.sv
// ----------------------------------------------------------------------------
// vt4x4_pkg
// Shared constants and types of the 4x4 vertex transform core.
// ----------------------------------------------------------------------------
package vt4x4_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIM         = 4;
    localparam int NUM_COMP    = 4;
    localparam int IN_IDX_W    = 2;
    localparam int IDX_W       = $clog2(DIM);
    localparam int DIM_W       = $clog2(DIM + 1);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] FIX_ONE = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    // Element value of a write travels in vec[0].
    typedef struct packed {
        t_op                              op;
        logic [IDX_W-1:0]                 row;
        logic [IDX_W-1:0]                 col;
        logic [NUM_COMP-1:0][DATA_W-1:0]  vec;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/core/vt4x4_front.sv
// ----------------------------------------------------------------------------
// vt4x4_front
// Accepts input transactions, decodes the mode and drops out-of-range writes.
// ----------------------------------------------------------------------------
module vt4x4_front (
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic [vt4x4_pkg::IN_IDX_W-1:0]        i_row_index,
    input  logic [vt4x4_pkg::IN_IDX_W-1:0]        i_col_index,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_load_value,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_x,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_y,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_z,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_w,
    input  vt4x4_pkg::t_q_status                  i_q_status,
    output logic                                  o_push,
    output vt4x4_pkg::t_item                      o_item
);

    logic idx_ok;

    assign idx_ok = (vt4x4_pkg::DIM_W'(i_row_index) < vt4x4_pkg::DIM_W'(vt4x4_pkg::DIM))
                 && (vt4x4_pkg::DIM_W'(i_col_index) < vt4x4_pkg::DIM_W'(vt4x4_pkg::DIM));

    assign o_in_ready = !i_q_status.full;

    // Accept a bad-index write but queue nothing for it.
    assign o_push = i_in_valid && o_in_ready && (i_mode || idx_ok);

    always_comb begin
        o_item.op     = i_mode ? vt4x4_pkg::OP_XFORM : vt4x4_pkg::OP_WRITE;
        o_item.row    = i_row_index[vt4x4_pkg::IDX_W-1:0];
        o_item.col    = i_col_index[vt4x4_pkg::IDX_W-1:0];
        o_item.vec[0] = i_mode ? i_vec_x : i_load_value;
        o_item.vec[1] = i_vec_y;
        o_item.vec[2] = i_vec_z;
        o_item.vec[3] = i_vec_w;
    end

endmodule

// File: rtl/core/vt4x4_queue.sv
// ----------------------------------------------------------------------------
// vt4x4_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_core_macros.svh"

module vt4x4_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  vt4x4_pkg::t_item       i_item,
    input  logic                   i_pop,
    output vt4x4_pkg::t_item       o_item,
    output vt4x4_pkg::t_q_status   o_status
);

    vt4x4_pkg::t_item                r_mem [vt4x4_pkg::QUEUE_DEPTH];
    logic [vt4x4_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [vt4x4_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [vt4x4_pkg::QCNT_W-1:0]    r_count;
    logic [vt4x4_pkg::QCNT_W-1:0]    n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_status.full  = (r_count == vt4x4_pkg::QCNT_W'(vt4x4_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `VT_ASSERT(a_q_no_overflow, !(i_push && o_status.full), "push into full queue")
    `VT_ASSERT(a_q_no_underflow, !(i_pop && o_status.empty), "pop from empty queue")
    `VT_ASSERT(a_q_count_range, r_count <= vt4x4_pkg::QCNT_W'(vt4x4_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/core/vt4x4_back.sv
// ----------------------------------------------------------------------------
// vt4x4_back
// Holds the matrix, applies queued writes and runs the transform pipeline:
// products, pair sums, row sums, then shift and saturate into the output.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_core_macros.svh"

module vt4x4_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  vt4x4_pkg::t_item                      i_q_item,
    input  vt4x4_pkg::t_q_status                  i_q_status,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_x,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_y,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_z,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_w,
    output logic                                  o_saturated
);

    localparam int HI_LSB = vt4x4_pkg::FRAC_BITS + vt4x4_pkg::DATA_W - 1;

    logic [vt4x4_pkg::DATA_W-1:0]         r_mat  [vt4x4_pkg::DIM][vt4x4_pkg::DIM];
    logic signed [vt4x4_pkg::PROD_W-1:0]  r_prod [vt4x4_pkg::DIM][vt4x4_pkg::DIM];
    logic signed [vt4x4_pkg::PAIR_W-1:0]  r_pair [vt4x4_pkg::DIM][2];
    logic signed [vt4x4_pkg::SUM_W-1:0]   r_sum  [vt4x4_pkg::DIM];
    logic [vt4x4_pkg::DATA_W-1:0]         r_out  [vt4x4_pkg::NUM_COMP];
    logic [vt4x4_pkg::DATA_W-1:0]         n_out  [vt4x4_pkg::NUM_COMP];
    logic [vt4x4_pkg::NUM_COMP-1:0]       n_clamp;
    logic                                 r_out_sat;
    logic                                 r_s1_valid;
    logic                                 r_s2_valid;
    logic                                 r_s3_valid;
    logic                                 r_out_valid;
    logic                                 adv;
    logic                                 is_xform;

    // Whole pipeline holds while the output waits.
    assign adv      = !r_out_valid || i_out_ready;
    assign o_pop    = adv && !i_q_status.empty;
    assign is_xform = (i_q_item.op == vt4x4_pkg::OP_XFORM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop && is_xform;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Matrix store: writes take effect in queue order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < vt4x4_pkg::DIM; r++) begin
                for (int c = 0; c < vt4x4_pkg::DIM; c++) begin
                    r_mat[r][c] <= (r == c) ? vt4x4_pkg::FIX_ONE : '0;
                end
            end
        end else if (o_pop && !is_xform) begin
            r_mat[i_q_item.row][i_q_item.col] <= i_q_item.vec[0];
        end
    end

    for (genvar gr = 0; gr < vt4x4_pkg::DIM; gr++) begin : g_row
        for (genvar gc = 0; gc < vt4x4_pkg::DIM; gc++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_prod[gr][gc] <= vt4x4_pkg::PROD_W'($signed(r_mat[gr][gc]))
                                    * vt4x4_pkg::PROD_W'($signed(i_q_item.vec[gc]));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pair[gr][0] <= vt4x4_pkg::PAIR_W'(r_prod[gr][0])
                               + vt4x4_pkg::PAIR_W'(r_prod[gr][1]);
            end
        end

        if (vt4x4_pkg::DIM == 4) begin : g_pair4
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_pair[gr][1] <= vt4x4_pkg::PAIR_W'(r_prod[gr][2])
                                   + vt4x4_pkg::PAIR_W'(r_prod[gr][3]);
                end
            end
        end else if (vt4x4_pkg::DIM == 3) begin : g_pair3
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_pair[gr][1] <= vt4x4_pkg::PAIR_W'(r_prod[gr][2]);
                end
            end
        end else begin : g_pair2
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_pair[gr][1] <= '0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sum[gr] <= vt4x4_pkg::SUM_W'(r_pair[gr][0])
                           + vt4x4_pkg::SUM_W'(r_pair[gr][1]);
            end
        end
    end

    // Shift and clamp: the value fits when all bits from the result's sign bit upward agree.
    always_comb begin
        logic [vt4x4_pkg::SUM_W-HI_LSB-1:0] hi;
        for (int r = 0; r < vt4x4_pkg::NUM_COMP; r++) begin
            n_out[r]   = '0;
            n_clamp[r] = 1'b0;
        end
        for (int r = 0; r < vt4x4_pkg::DIM; r++) begin
            hi         = r_sum[r][vt4x4_pkg::SUM_W-1:HI_LSB];
            n_clamp[r] = !((&hi) || !(|hi));
            if (n_clamp[r]) begin
                n_out[r] = r_sum[r][vt4x4_pkg::SUM_W-1] ? vt4x4_pkg::SAT_MIN
                                                        : vt4x4_pkg::SAT_MAX;
            end else begin
                n_out[r] = r_sum[r][HI_LSB:vt4x4_pkg::FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < vt4x4_pkg::NUM_COMP; r++) begin
                r_out[r] <= n_out[r];
            end
            r_out_sat <= |n_clamp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];
    assign o_saturated = r_out_sat;

    `VT_ASSERT(a_bk_pop_nonempty, o_pop |-> !i_q_status.empty, "pop while queue empty")
    `VT_ASSERT(a_bk_s3_to_out, (r_s3_valid && adv) |=> r_out_valid,
               "result lost between sum and output")
    `VT_ASSERT(a_bk_sat_clamped,
               (r_out_valid && r_out_sat) |->
                   (r_out[0] == vt4x4_pkg::SAT_MAX || r_out[0] == vt4x4_pkg::SAT_MIN ||
                    r_out[1] == vt4x4_pkg::SAT_MAX || r_out[1] == vt4x4_pkg::SAT_MIN ||
                    r_out[2] == vt4x4_pkg::SAT_MAX || r_out[2] == vt4x4_pkg::SAT_MIN ||
                    r_out[3] == vt4x4_pkg::SAT_MAX || r_out[3] == vt4x4_pkg::SAT_MIN),
               "saturation flag without a clamped component")

endmodule

// File: rtl/core/vertex_transform_4x4_core.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4_core
// Q16.16 4x4 matrix times vector with shift and saturation; element writes
// and transforms share one input stream.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  input    i_in_valid / o_in_ready   i_mode, i_row_index, i_col_index,
//                                     i_load_value, i_vec_x .. i_vec_w
//  output   o_out_valid / i_out_ready o_out_x .. o_out_w, o_saturated
//
//  One transaction per cycle sustained while the output is not stalled, writes and transforms alike.
//  A transform result is registered in the queue, products, pair sums,
//  row sums and output register before it is valid.
//  A write affects every transform accepted after it.
//  Reset loads the identity matrix and empties the queue and pipeline.
//  An output stall holds the pipeline; the two-entry queue then fills and
//  o_in_ready drops.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic [vt4x4_pkg::IN_IDX_W-1:0]        i_row_index,
    input  logic [vt4x4_pkg::IN_IDX_W-1:0]        i_col_index,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_load_value,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_x,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_y,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_z,
    input  logic signed [vt4x4_pkg::DATA_W-1:0]   i_vec_w,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_x,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_y,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_z,
    output logic signed [vt4x4_pkg::DATA_W-1:0]   o_out_w,
    output logic                                  o_saturated
);

    vt4x4_pkg::t_q_status q_status;
    vt4x4_pkg::t_item     push_item;
    vt4x4_pkg::t_item     head_item;
    logic                 push;
    logic                 pop;

    vt4x4_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_load_value (i_load_value),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_vec_w      (i_vec_w),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_item       (push_item)
    );

    vt4x4_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    vt4x4_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_item    (head_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w),
        .o_saturated (o_saturated)
    );

endmodule
